/* hw/rtl/bsa_pkg.sv */
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared field widths, codes and types for the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    // field widths
    localparam int OP_W       = 2;
    localparam int OFFSET_W   = 26;
    localparam int STATUS_W   = 2;
    localparam int SIZE_W     = 17;
    localparam int LEN_W      = 11;

    // port widths
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 17;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_OBJ_BYTES  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_COUNT = 1'b1;

    // op codes on the input stream
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NOT_ALLOC = 2'd2;
    localparam logic [STATUS_W-1:0] STS_RANGE     = 2'd3;

    // register reset values and limits
    localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd64;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 17'd65536;
    localparam logic [LEN_W-1:0]  LEN_RESET  = 11'd1024;
    localparam logic [LEN_W-1:0]  LEN_MAX    = 11'd1024;

    typedef enum logic [1:0] {
        K_ALLOC,
        K_FREE,
        K_CLEAR,
        K_NOP
    } t_kind;

    // one classified command between front and back
    typedef struct packed {
        t_kind                kind;
        logic [OFFSET_W-1:0]  offset;
    } t_cmd;

    // effective configuration, already clamped
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [LEN_W-1:0]  len;
    } t_cfg;

endpackage

/* hw/rtl/bsa_ram.sv */
// ----------------------------------------------------------------------------
// bsa_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/bsa_div.sv */
// ----------------------------------------------------------------------------
// bsa_div
// Restoring divider, one quotient bit per cycle: offset / object size.
// ----------------------------------------------------------------------------
module bsa_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bsa_pkg::OFFSET_W-1:0]  i_dividend,
    input  logic [bsa_pkg::SIZE_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [bsa_pkg::OFFSET_W-1:0]  o_quotient
);
    import bsa_pkg::*;

    localparam int CNT_W = $clog2(OFFSET_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(OFFSET_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [SIZE_W-1:0]     r_rem;
    logic [OFFSET_W-1:0]   r_quo;

    logic [SIZE_W:0]       shifted;
    logic                  fits;

    // partial remainder shifted with the next dividend bit
    assign shifted = {r_rem, r_quo[OFFSET_W-1]};
    assign fits    = (shifted >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == LAST_STEP);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= SIZE_W'(shifted - {1'b0, i_divisor});
            end else begin
                r_rem <= shifted[SIZE_W-1:0];
            end
            r_quo <= {r_quo[OFFSET_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* hw/rtl/bsa_fifo.sv */
// ----------------------------------------------------------------------------
// bsa_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module bsa_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bsa_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output bsa_pkg::t_cmd  o_cmd
);
    import bsa_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

endmodule

/* hw/rtl/bsa_front.sv */
// ----------------------------------------------------------------------------
// bsa_front
// Config registers, input beat acceptance and op classification.
// ----------------------------------------------------------------------------
module bsa_front #(
    parameter int WORD_BITS = 64,
    parameter int MAP_WORDS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bsa_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bsa_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                            i_init_busy,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output bsa_pkg::t_cmd                   o_q_cmd,
    output bsa_pkg::t_cfg                   o_cfg
);
    import bsa_pkg::*;

    localparam int CAP = WORD_BITS * MAP_WORDS;
    localparam logic [LEN_W-1:0] LEN_CAP = (CAP < int'(LEN_MAX)) ? LEN_W'(CAP) : LEN_MAX;

    logic [SIZE_W-1:0] r_size;
    logic [LEN_W-1:0]  r_len;
    logic [OP_W-1:0]   op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
            r_len  <= LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_OBJ_BYTES:  r_size <= i_cfg_data;
                CFG_SLOT_COUNT: r_len  <= i_cfg_data[LEN_W-1:0];
                default:        r_size <= r_size;
            endcase
        end
    end

    // clamp: zero acts as one, large values saturate
    always_comb begin
        o_cfg.size = r_size;
        if (r_size == '0) begin
            o_cfg.size = SIZE_W'(1);
        end else if (r_size > SIZE_MAX) begin
            o_cfg.size = SIZE_MAX;
        end
        o_cfg.len = r_len;
        if (r_len == '0) begin
            o_cfg.len = LEN_W'(1);
        end else if (r_len > LEN_CAP) begin
            o_cfg.len = LEN_CAP;
        end
    end

    assign op = s_axis_tdata[OP_W-1:0];

    always_comb begin
        o_q_cmd.offset = s_axis_tdata[OP_W +: OFFSET_W];
        case (op)
            OP_ALLOC: o_q_cmd.kind = K_ALLOC;
            OP_FREE:  o_q_cmd.kind = K_FREE;
            OP_CLEAR: o_q_cmd.kind = K_CLEAR;
            default:  o_q_cmd.kind = K_NOP;
        endcase
    end

    assign s_axis_tready = !i_q_full && !i_init_busy;
    assign o_q_push      = s_axis_tvalid && s_axis_tready;

endmodule

/* hw/rtl/bsa_back.sv */
// ----------------------------------------------------------------------------
// bsa_back
// Executes commands on the slot bitmap: word scan, divide, update, result.
// ----------------------------------------------------------------------------
module bsa_back #(
    parameter int WORD_BITS = 64,
    parameter int MAP_WORDS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bsa_pkg::t_cfg                  i_cfg,
    input  logic                           i_q_valid,
    input  bsa_pkg::t_cmd                  i_q_cmd,
    output logic                           o_q_pop,
    output logic                           o_init_busy,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bsa_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import bsa_pkg::*;

    localparam int WA_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int CAP     = WORD_BITS * MAP_WORDS;
    localparam int LEN_CAP = (CAP < int'(LEN_MAX)) ? CAP : int'(LEN_MAX);
    localparam int SLOT_W  = $clog2(LEN_CAP);
    localparam int CMP_W   = ($clog2(CAP) + 1 > LEN_W) ? $clog2(CAP) + 1 : LEN_W;
    // slot / WORD_BITS by reciprocal multiply, exact for every slot index
    localparam int RK      = SLOT_W + BIT_W + 1;
    localparam int PW      = RK + WA_W + 1;
    localparam logic [PW-1:0] RECIP = PW'(((1 << RK) + WORD_BITS - 1) / WORD_BITS);
    localparam logic [WA_W-1:0] LAST_WORD = WA_W'(MAP_WORDS - 1);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLR,
        ST_DIV,
        ST_SPLIT,
        ST_FRD,
        ST_FCHK,
        ST_SCAN,
        ST_AMUL,
        ST_DONE
    } t_state;

    // bits at or beyond the pool length read as taken
    function automatic logic [WORD_BITS-1:0] taken_mask(
        input logic [WA_W-1:0]  w,
        input logic [LEN_W-1:0] len
    );
        logic [CMP_W-1:0]     base;
        logic [CMP_W-1:0]     lim;
        logic [WORD_BITS-1:0] m;
        base = CMP_W'(w) * CMP_W'(WORD_BITS);
        lim  = '0;
        if (base >= CMP_W'(len)) begin
            m = '1;
        end else begin
            lim = CMP_W'(len) - base;
            if (lim >= CMP_W'(WORD_BITS)) begin
                m = '0;
            end else begin
                m = {WORD_BITS{1'b1}} << lim;
            end
        end
        return m;
    endfunction

    // lowest clear bit: {found, position}
    function automatic logic [BIT_W:0] first_zero(input logic [WORD_BITS-1:0] m);
        logic             f;
        logic [BIT_W-1:0] b;
        f = 1'b0;
        b = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!m[i]) begin
                f = 1'b1;
                b = BIT_W'(i);
            end
        end
        return {f, b};
    endfunction

    t_state                r_state;
    logic [WA_W-1:0]       r_sw_addr;
    logic [LEN_W-1:0]      r_sw_len;
    logic [WA_W-1:0]       r_sc_addr;
    logic [WA_W-1:0]       r_sc_chk;
    logic                  r_sc_pend;
    logic                  r_sc_alloc;
    logic                  r_div_start;
    logic [OFFSET_W-1:0]   r_cmd_off;
    logic [SLOT_W-1:0]     r_idx;
    logic [WA_W-1:0]       r_w;
    logic [BIT_W-1:0]      r_b;
    logic [SLOT_W-1:0]     r_slot;
    logic [OFFSET_W-1:0]   r_res_off;
    logic [STATUS_W-1:0]   r_res_sts;
    logic                  r_res_full;
    logic                  r_out_valid;
    logic [M_TDATA_W-1:0]  r_out_data;

    logic                  ram_we;
    logic [WA_W-1:0]       ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [WA_W-1:0]       ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;

    logic                  div_done;
    logic [OFFSET_W-1:0]   div_q;

    logic [WORD_BITS-1:0]  sc_masked;
    logic [BIT_W:0]        sc_hit;
    logic                  sc_found;
    logic [BIT_W-1:0]      sc_b;
    logic                  sc_last;
    logic [CMP_W-1:0]      sc_slot;
    logic [PW-1:0]         sp_prod;
    logic [CMP_W-1:0]      fr_bit;
    logic [WORD_BITS-1:0]  fr_onehot;
    logic [WORD_BITS-1:0]  sc_onehot;
    logic                  out_free;

    bsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_cmd_off),
        .i_divisor  (i_cfg.size),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // scan check on the word that came back from the RAM
    assign sc_masked = ram_rdata | taken_mask(r_sc_chk, i_cfg.len);
    assign sc_hit    = first_zero(sc_masked);
    assign sc_found  = sc_hit[BIT_W];
    assign sc_b      = sc_hit[BIT_W-1:0];
    assign sc_last   = (CMP_W'(r_sc_chk) * CMP_W'(WORD_BITS) + CMP_W'(WORD_BITS))
                       >= CMP_W'(i_cfg.len);
    assign sc_slot   = CMP_W'(r_sc_chk) * CMP_W'(WORD_BITS) + CMP_W'(sc_b);
    assign sc_onehot = WORD_BITS'(1) << sc_b;

    assign sp_prod   = PW'(r_idx) * RECIP;
    assign fr_bit    = CMP_W'(r_idx) - CMP_W'(r_w) * CMP_W'(WORD_BITS);
    assign fr_onehot = WORD_BITS'(1) << r_b;

    assign out_free  = !r_out_valid || m_axis_tready;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_sw_addr;
        ram_wdata = taken_mask(r_sw_addr, r_sw_len);
        ram_raddr = r_sc_addr;
        case (r_state)
            ST_INIT, ST_CLR: begin
                ram_we = 1'b1;
            end
            ST_FRD: begin
                ram_raddr = r_w;
            end
            ST_FCHK: begin
                ram_we    = ram_rdata[r_b];
                ram_waddr = r_w;
                ram_wdata = ram_rdata & ~fr_onehot;
            end
            ST_SCAN: begin
                ram_we    = r_sc_pend && sc_found && r_sc_alloc;
                ram_waddr = r_sc_chk;
                ram_wdata = ram_rdata | sc_onehot;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign o_q_pop     = (r_state == ST_IDLE) && i_q_valid;
    assign o_init_busy = (r_state == ST_INIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_sw_addr   <= '0;
            r_sw_len    <= LEN_W'(LEN_CAP);
            r_sc_pend   <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // divider kicks off in the cycle after a free is popped
            r_div_start <= o_q_pop && (i_q_cmd.kind == K_FREE);
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_INIT: begin
                    r_sw_addr <= r_sw_addr + 1'b1;
                    if (r_sw_addr == LAST_WORD) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd_off  <= i_q_cmd.offset;
                        r_res_off  <= '0;
                        r_res_sts  <= STS_OK;
                        r_res_full <= 1'b0;
                        r_sc_addr  <= '0;
                        r_sc_pend  <= 1'b0;
                        r_sc_alloc <= (i_q_cmd.kind == K_ALLOC);
                        case (i_q_cmd.kind)
                            K_ALLOC: begin
                                r_state <= ST_SCAN;
                            end
                            K_FREE: begin
                                r_state <= ST_DIV;
                            end
                            K_CLEAR: begin
                                r_sw_addr <= '0;
                                r_sw_len  <= i_cfg.len;
                                r_state   <= ST_CLR;
                            end
                            default: begin
                                r_state <= ST_SCAN;
                            end
                        endcase
                    end
                end
                ST_CLR: begin
                    r_sw_addr <= r_sw_addr + 1'b1;
                    if (r_sw_addr == LAST_WORD) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (div_q >= OFFSET_W'(i_cfg.len)) begin
                            // out of range: map unchanged, fullness from a scan
                            r_res_sts <= STS_RANGE;
                            r_state   <= ST_SCAN;
                        end else begin
                            r_idx   <= div_q[SLOT_W-1:0];
                            r_state <= ST_SPLIT;
                        end
                    end
                end
                ST_SPLIT: begin
                    r_w     <= sp_prod[RK +: WA_W];
                    r_state <= ST_FRD;
                end
                ST_FRD: begin
                    r_b     <= fr_bit[BIT_W-1:0];
                    r_state <= ST_FCHK;
                end
                ST_FCHK: begin
                    // the slot is usable, so after a free the pool is never full
                    if (!ram_rdata[r_b]) begin
                        r_res_sts <= STS_NOT_ALLOC;
                    end
                    r_state <= ST_DONE;
                end
                ST_SCAN: begin
                    r_sc_addr <= r_sc_addr + 1'b1;
                    r_sc_chk  <= r_sc_addr;
                    r_sc_pend <= 1'b1;
                    if (r_sc_pend) begin
                        if (sc_found) begin
                            if (r_sc_alloc) begin
                                r_slot  <= sc_slot[SLOT_W-1:0];
                                r_w     <= r_sc_chk;
                                r_state <= ST_AMUL;
                            end else begin
                                r_res_full <= 1'b0;
                                r_state    <= ST_DONE;
                            end
                        end else if (sc_last) begin
                            if (r_sc_alloc) begin
                                r_res_sts <= STS_FULL;
                            end
                            r_res_full <= 1'b1;
                            r_state    <= ST_DONE;
                        end
                    end
                end
                ST_AMUL: begin
                    // offset, then rescan from the word just written
                    r_res_off  <= OFFSET_W'(r_slot) * OFFSET_W'(i_cfg.size);
                    r_sc_alloc <= 1'b0;
                    r_sc_addr  <= r_w;
                    r_sc_pend  <= 1'b0;
                    r_state    <= ST_SCAN;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_data <= M_TDATA_W'({r_res_full, r_res_sts, r_res_off});
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* hw/rtl/bitmap_slot_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// First-fit allocator for a pool of fixed-size objects kept as a bitmap.
//
//  channel   dir  beat fields (lowest bit up)
//  -------   ---  ----------------------------------------------------------
//  s_axis    in   op[1:0], free_offset[27:2], zero pad to 32
//  m_axis    out  alloc_offset[25:0], status[27:26], pool_full[28], pad to 32
//  cfg       in   i_cfg_addr 0 object size in bytes (17b), 1 slot count (11b)
//
//  Allocate scans map words one per cycle from word 0 until a usable clear
//  bit, then rescans from that word for the fullness flag. Free runs a
//  one-bit-per-cycle divider, then reads and updates the map word; an
//  out-of-range free leaves the map unchanged and scans for the fullness
//  flag instead. Clear rewrites every word. After reset the map is swept
//  with s_axis_tready low; config writes are taken meanwhile. A two-beat
//  command queue and the output register let the input side run ahead of
//  a stalled m_axis.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator #(
    parameter int WORD_BITS = 64,
    parameter int MAP_WORDS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port
    input  logic                            i_cfg_we,
    input  logic [bsa_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bsa_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // op, free_offset
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bsa_pkg::M_TDATA_W-1:0]   m_axis_tdata   // alloc_offset, status, pool_full
);
    import bsa_pkg::*;

    t_cfg cfg;
    t_cmd push_cmd;
    t_cmd pop_cmd;
    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic init_busy;

    // front: config registers and op classification
    bsa_front #(
        .WORD_BITS (WORD_BITS),
        .MAP_WORDS (MAP_WORDS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_init_busy   (init_busy),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_cmd       (push_cmd),
        .o_cfg         (cfg)
    );

    // decouples request acceptance from execution
    bsa_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (pop_cmd)
    );

    // back: bitmap RAM, scan, divider and result register
    bsa_back #(
        .WORD_BITS (WORD_BITS),
        .MAP_WORDS (MAP_WORDS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_q_valid     (q_valid),
        .i_q_cmd       (pop_cmd),
        .o_q_pop       (q_pop),
        .o_init_busy   (init_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
